/* hdl/ebc_pkg.sv */
// ----------------------------------------------------------------------------
// ebc_pkg
// Shared types, MD5 constants and round helper functions for the empty
// block classifier.
// ----------------------------------------------------------------------------
package ebc_pkg;

    // Sequencer states of the hash engine
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FINISH
    } ebc_state_t;

    // Emptiness tests
    typedef enum logic [1:0] {
        MODE_ZERO    = 2'd0,
        MODE_PATTERN = 2'd1,
        MODE_MD5     = 2'd2,
        MODE_NONE    = 2'd3
    } skip_mode_t;

    // Configuration register indexes
    localparam logic REG_SKIP_MODE    = 1'b0;
    localparam logic REG_SKIP_PATTERN = 1'b1;

    localparam logic [31:0] MD5_INIT_A = 32'h67452301;
    localparam logic [31:0] MD5_INIT_B = 32'hefcdab89;
    localparam logic [31:0] MD5_INIT_C = 32'h98badcfe;
    localparam logic [31:0] MD5_INIT_D = 32'h10325476;
    localparam logic [31:0] MD5_PAD_WORD = 32'h00000080;

    // Round additive constants
    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Rotate amount for round i
    function automatic logic [4:0] md5_s(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Message word index for round i
    function automatic logic [3:0] md5_g(input logic [5:0] i);
        logic [3:0] g;
        case (i[5:4])
            2'd0:    g = i[3:0];
            2'd1:    g = 4'(5 * i + 1);
            2'd2:    g = 4'(3 * i + 5);
            default: g = 4'(7 * i);
        endcase
        return g;
    endfunction

    // Round boolean function
    function automatic logic [31:0] md5_f(input logic [5:0] i, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (i[5:4])
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] t;
        t = {x, x} << s;
        return t[63:32];
    endfunction

endpackage

/* hdl/empty_block_classifier.sv */
// Every 16th hashed word starts a compression: load, 64 rounds of one round
// per cycle reading the chunk memory, chain update.
// A full block in MD5 mode adds a padding compression at its end, or two
// when the tail leaves no room for the length.
// No input word is accepted while a compression runs.
// Reset clears control state and the hash chain; the chunk memory is not cleared.
// ----------------------------------------------------------------------------
// empty_block_classifier
// Classifies fixed-size blocks of a word stream as empty or to be saved,
// by zero test, pattern test or self-certifying MD5 check.
// ----------------------------------------------------------------------------
module empty_block_classifier
    import ebc_pkg::*;
#(
    parameter int BLOCK_BYTES = 4096
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] data_word,
    input  logic [2:0]  word_bytes,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        save_block,
    output logic [31:0] block_number,
    output logic [12:0] block_len
);

    localparam int BLOCK_WORDS  = BLOCK_BYTES / 4;
    localparam int HASHED_WORDS = BLOCK_WORDS - 4;
    localparam int TAIL         = HASHED_WORDS % 16;
    localparam bit TWO_PASS     = (TAIL >= 14);
    localparam logic [63:0] LEN_BITS = 64'(BLOCK_BYTES - 16) * 64'd8;
    localparam int WPW = $clog2(BLOCK_WORDS + 1);
    localparam int BCW = $clog2(BLOCK_BYTES + 1);

    // Configuration
    logic [1:0]  mode_reg;
    logic [31:0] pattern_reg;

    // Block tracking
    ebc_state_t     state_reg, state_next;
    logic [WPW-1:0] wpos_reg, wpos_next;
    logic [BCW-1:0] bytes_reg, bytes_next;
    logic           mism_reg, mism_next;
    logic [31:0]    bnum_reg, bnum_next;
    logic [31:0]    dig_reg [4];
    logic [31:0]    h_reg [4];
    logic [31:0]    h_next [4];

    // Hash engine
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] a_next, b_next, c_next, d_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [3:0]  g_reg, g_next;
    logic        final_reg, final_next;
    logic        pass_reg, pass_next;

    // Chunk memory
    logic [31:0] mem [16];
    logic [31:0] rdata_reg;
    logic        mem_we;
    logic [3:0]  mem_raddr;

    // Output stage
    logic        ov_reg, ov_next;
    logic        save_reg, save_next;
    logic [31:0] onum_reg, onum_next;
    logic [12:0] osize_reg, osize_next;

    // Accept-time terms
    logic           accept;
    logic [2:0]     nb;
    logic [BCW-1:0] bytes_sum;
    logic [WPW-1:0] wpos_inc;
    logic           in_hash;
    logic           blk_end;
    logic           full_blk;
    logic           mism_sum;
    logic [WPW-1:0] dig_off;
    logic [31:0]    msg;
    logic [31:0]    rsum;
    logic [31:0]    hsum [4];
    logic           dig_eq;

    assign in_ready     = (state_reg == ST_IDLE) && (!ov_reg || out_ready);
    assign accept       = in_valid && in_ready;
    assign out_valid    = ov_reg;
    assign save_block   = save_reg;
    assign block_number = onum_reg;
    assign block_len    = osize_reg;

    assign nb        = (word_bytes > 3'd4) ? 3'd4 : word_bytes;
    assign bytes_sum = bytes_reg + BCW'(nb);
    assign wpos_inc  = wpos_reg + 1'b1;
    assign in_hash   = wpos_reg < WPW'(HASHED_WORDS);
    assign blk_end   = last_word || (wpos_inc == WPW'(BLOCK_WORDS));
    assign full_blk  = bytes_sum == BCW'(BLOCK_BYTES);
    assign mism_sum  = mism_reg ||
                       (data_word != ((mode_reg == MODE_PATTERN) ? pattern_reg : 32'h0));
    assign dig_off   = wpos_reg - WPW'(HASHED_WORDS);
    assign mem_we    = accept && in_hash;

    // Message word with padding substituted for the closing compression
    always_comb
    begin
        msg = 32'h0;
        if (!final_reg)
            msg = rdata_reg;
        else if (pass_reg || TWO_PASS)
        begin
            if (!pass_reg && g_reg < 4'(TAIL))
                msg = rdata_reg;
            else if (!pass_reg && g_reg == 4'(TAIL))
                msg = MD5_PAD_WORD;
            else if (pass_reg && g_reg == 4'd14)
                msg = LEN_BITS[31:0];
            else if (pass_reg && g_reg == 4'd15)
                msg = LEN_BITS[63:32];
        end
        else
        begin
            if (g_reg < 4'(TAIL))
                msg = rdata_reg;
            else if (g_reg == 4'(TAIL))
                msg = MD5_PAD_WORD;
            else if (g_reg == 4'd14)
                msg = LEN_BITS[31:0];
            else if (g_reg == 4'd15)
                msg = LEN_BITS[63:32];
        end
    end

    // One MD5 round
    assign rsum = md5_f(rnd_reg, b_reg, c_reg, d_reg) + a_reg + md5_k(rnd_reg) + msg;

    // Chain update and digest check
    assign hsum[0] = h_reg[0] + a_reg;
    assign hsum[1] = h_reg[1] + b_reg;
    assign hsum[2] = h_reg[2] + c_reg;
    assign hsum[3] = h_reg[3] + d_reg;
    assign dig_eq  = (hsum[0] == dig_reg[0]) && (hsum[1] == dig_reg[1]) &&
                     (hsum[2] == dig_reg[2]) && (hsum[3] == dig_reg[3]);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !blk_end && in_hash && wpos_reg[3:0] == 4'hf)
                    state_next = ST_LOAD;
                else if (accept && blk_end && full_blk && mode_reg == MODE_MD5)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
                state_next = ST_ROUND;
            ST_ROUND:
            begin
                if (rnd_reg == 6'd63)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (final_reg && !pass_reg && TWO_PASS)
                    state_next = ST_LOAD;
                else
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        wpos_next  = wpos_reg;
        bytes_next = bytes_reg;
        mism_next  = mism_reg;
        bnum_next  = bnum_reg;
        h_next     = h_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        rnd_next   = rnd_reg;
        g_next     = g_reg;
        final_next = final_reg;
        pass_next  = pass_reg;
        mem_raddr  = md5_g(6'd0);
        ov_next    = ov_reg && !out_ready;
        save_next  = save_reg;
        onum_next  = onum_reg;
        osize_next = osize_reg;

        case (state_reg)
            ST_IDLE:
            begin
                a_next = h_reg[0];
                b_next = h_reg[1];
                c_next = h_reg[2];
                d_next = h_reg[3];
                if (accept)
                begin
                    wpos_next  = wpos_inc;
                    bytes_next = bytes_sum;
                    mism_next  = mism_sum;
                    final_next = 1'b0;
                    pass_next  = 1'b0;
                    if (blk_end)
                    begin
                        if (full_blk && mode_reg == MODE_MD5)
                            final_next = 1'b1;
                        else
                        begin
                            // Block closes here: restart tracking
                            wpos_next  = '0;
                            bytes_next = '0;
                            mism_next  = 1'b0;
                            h_next[0]  = MD5_INIT_A;
                            h_next[1]  = MD5_INIT_B;
                            h_next[2]  = MD5_INIT_C;
                            h_next[3]  = MD5_INIT_D;
                            if (bytes_sum != '0)
                            begin
                                ov_next    = 1'b1;
                                save_next  = !full_blk || mode_reg == MODE_NONE ||
                                             mode_reg == MODE_MD5 || mism_sum;
                                onum_next  = bnum_reg;
                                osize_next = 13'(bytes_sum);
                                bnum_next  = bnum_reg + 32'd1;
                            end
                        end
                    end
                end
            end
            ST_LOAD:
            begin
                rnd_next  = 6'd0;
                g_next    = md5_g(6'd0);
                mem_raddr = md5_g(6'd0);
            end
            ST_ROUND:
            begin
                a_next    = d_reg;
                d_next    = c_reg;
                c_next    = b_reg;
                b_next    = b_reg + rotl32(rsum, md5_s(rnd_reg));
                rnd_next  = rnd_reg + 6'd1;
                g_next    = md5_g(rnd_reg + 6'd1);
                mem_raddr = md5_g(rnd_reg + 6'd1);
            end
            ST_FINISH:
            begin
                h_next = hsum;
                a_next = hsum[0];
                b_next = hsum[1];
                c_next = hsum[2];
                d_next = hsum[3];
                if (final_reg && !pass_reg && TWO_PASS)
                    pass_next = 1'b1;
                else if (final_reg)
                begin
                    ov_next    = 1'b1;
                    save_next  = !dig_eq;
                    onum_next  = bnum_reg;
                    osize_next = 13'(bytes_reg);
                    bnum_next  = bnum_reg + 32'd1;
                    wpos_next  = '0;
                    bytes_next = '0;
                    mism_next  = 1'b0;
                    final_next = 1'b0;
                    h_next[0]  = MD5_INIT_A;
                    h_next[1]  = MD5_INIT_B;
                    h_next[2]  = MD5_INIT_C;
                    h_next[3]  = MD5_INIT_D;
                end
            end
            default:
            begin
                ov_next = ov_reg;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_ZERO;
            pattern_reg <= 32'h0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SKIP_MODE:    mode_reg    <= cfg_data[1:0];
                REG_SKIP_PATTERN: pattern_reg <= cfg_data;
                default:          mode_reg    <= mode_reg;
            endcase
        end
    end

    // Control and chain registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wpos_reg  <= '0;
            bytes_reg <= '0;
            mism_reg  <= 1'b0;
            bnum_reg  <= 32'h0;
            h_reg[0]  <= MD5_INIT_A;
            h_reg[1]  <= MD5_INIT_B;
            h_reg[2]  <= MD5_INIT_C;
            h_reg[3]  <= MD5_INIT_D;
            rnd_reg   <= 6'd0;
            final_reg <= 1'b0;
            pass_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wpos_reg  <= wpos_next;
            bytes_reg <= bytes_next;
            mism_reg  <= mism_next;
            bnum_reg  <= bnum_next;
            h_reg     <= h_next;
            rnd_reg   <= rnd_next;
            final_reg <= final_next;
            pass_reg  <= pass_next;
            ov_reg    <= ov_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        d_reg     <= d_next;
        g_reg     <= g_next;
        save_reg  <= save_next;
        onum_reg  <= onum_next;
        osize_reg <= osize_next;
        if (accept && !in_hash)
            dig_reg[dig_off[1:0]] <= data_word;
    end

    // Chunk memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wpos_reg[3:0]] <= data_word;
        rdata_reg <= mem[mem_raddr];
    end

    // Checks
    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && rnd_reg == 6'd63) |=> state_reg == ST_FINISH)
        else $error("round sequence did not end in chain update");

    // position sits at the block end while the closing digest runs
    a_wpos_range: assert property (@(posedge clk) disable iff (!rst_n)
        wpos_reg <= WPW'(BLOCK_WORDS))
        else $error("word position passed block end");

    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && final_reg && !(!pass_reg && TWO_PASS)) |-> !ov_reg)
        else $error("digest verdict would overwrite a pending result");

endmodule
